@@ rtl/utf8sf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sf_pkg
// Shared constants, types and helpers for the UTF-8 stream filter.
// ----------------------------------------------------------------------------
package utf8sf_pkg;

	localparam int GRP_MAX    = 4;   // longest character group
	localparam int HOLD_DEPTH = 3;   // bytes kept while a group is open
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [7:0] QMARK     = 8'd63;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_DEL    = 8'd127;

	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	// One finished character group, handed from front to back.
	typedef struct packed {
		logic [GRP_MAX-1:0][7:0] bytes;
		logic [1:0]              last_idx;  // group length minus one
		logic                    bad;       // replace every byte with '?'
		logic                    buf_last;  // group closes the buffer
		logic                    buf_ok;    // buffer validity through this group
	} grp_rec_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		if ((b & 8'd248) == 8'd240)
			return LEN_FOUR;
		else if ((b & 8'd240) == 8'd224)
			return LEN_THREE;
		else if ((b & 8'd224) == 8'd192)
			return LEN_TWO;
		else
			return LEN_NONE;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage
`default_nettype wire

@@ rtl/utf8_stream_filter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_filter_core
// UTF-8 validating filter: passes valid characters, replaces each byte of an
// invalid or cut-short group with '?', and tracks whole-buffer validity.
// ----------------------------------------------------------------------------
//  channel   dir  tdata          tuser                      tlast
//  s_axis    in   data_byte      -                          last_in_buffer
//  m_axis    out  out_byte       [0] run_end [1] buffer_ok  buffer_end
//  cfg       in   cfg_wdata = allow_control, written when cfg_we is high
//
// One input byte is taken per cycle unless the group queue is full, and one
// output byte is sent per cycle while m_axis_tready is high. A group of n
// bytes is released as n output bytes once its last byte is in.
// A four-entry group queue sits between the classifier and the output
// unroller; s_axis_tready drops only when that queue is full.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_stream_filter_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]      m_axis_tuser,   // [0] run_end, [1] buffer_ok
	output logic            m_axis_tlast
);

	utf8sf_pkg::grp_rec_t push_rec;
	utf8sf_pkg::grp_rec_t head;
	logic                 push;
	logic                 full;
	logic                 pop;
	logic                 empty;

	utf8sf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.rec_push  (push),
		.rec       (push_rec),
		.rec_full  (full)
	);

	utf8sf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	utf8sf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.out_run_end (m_axis_tuser[0]),
		.out_buf_end (m_axis_tlast),
		.out_buf_ok  (m_axis_tuser[1])
	);

endmodule
`default_nettype wire

@@ rtl/utf8sf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sf_front
// Classifies incoming bytes, assembles multi-byte groups and emits one
// group record per finished group.
// ----------------------------------------------------------------------------
module utf8sf_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                in_valid,
	input  wire logic [7:0]          in_byte,
	input  wire logic                in_last,
	output logic                     in_ready,
	output logic                     rec_push,
	output utf8sf_pkg::grp_rec_t     rec,
	input  wire logic                rec_full
);

	logic                 allow_ctrl_q;
	logic [utf8sf_pkg::HOLD_DEPTH-1:0][7:0] held_q;
	logic [1:0]           held_cnt_q;
	logic [2:0]           grp_len_q;
	logic                 valid_q;

	logic                 take;
	logic                 emit;
	logic                 hold;
	logic                 bad;
	logic [2:0]           len_new;
	logic [2:0]           cnt;

	assign in_ready = !rec_full;
	assign take     = in_valid && in_ready;
	assign len_new  = utf8sf_pkg::lead_len(in_byte);
	assign cnt      = {1'b0, held_cnt_q} + 3'd1;

	always_comb begin
		emit          = 1'b0;
		hold          = 1'b0;
		bad           = 1'b0;
		rec.bytes[0]  = (held_cnt_q > 2'd0) ? held_q[0] : in_byte;
		rec.bytes[1]  = (held_cnt_q > 2'd1) ? held_q[1] : in_byte;
		rec.bytes[2]  = (held_cnt_q > 2'd2) ? held_q[2] : in_byte;
		rec.bytes[3]  = in_byte;
		rec.last_idx  = held_cnt_q;
		if (grp_len_q == utf8sf_pkg::LEN_NONE) begin
			rec.last_idx = 2'd0;
			if ((in_byte >= utf8sf_pkg::CH_SPACE && in_byte < utf8sf_pkg::CH_DEL) ||
			    in_byte == utf8sf_pkg::CH_TAB || in_byte == utf8sf_pkg::CH_LF) begin
				emit = 1'b1;
			end else if (in_byte < utf8sf_pkg::CH_SPACE || in_byte == utf8sf_pkg::CH_DEL) begin
				emit = 1'b1;
				bad  = !allow_ctrl_q;
			end else if (len_new == utf8sf_pkg::LEN_NONE || in_last) begin
				emit = 1'b1;
				bad  = 1'b1;
			end else begin
				hold = 1'b1;
			end
		end else if (cnt >= grp_len_q) begin
			// group complete: check lead of a 4-byte group and all continuations
			emit = 1'b1;
			bad  = (grp_len_q == utf8sf_pkg::LEN_FOUR && held_q[0][2:0] != 3'd0) ||
			       (held_cnt_q > 2'd1 && !utf8sf_pkg::is_cont(held_q[1])) ||
			       (held_cnt_q > 2'd2 && !utf8sf_pkg::is_cont(held_q[2])) ||
			       !utf8sf_pkg::is_cont(in_byte);
		end else if (in_last) begin
			emit = 1'b1;
			bad  = 1'b1;
		end else begin
			hold = 1'b1;
		end
		rec.bad      = bad;
		rec.buf_last = in_last;
		rec.buf_ok   = valid_q && !bad;
	end

	assign rec_push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_ctrl_q <= 1'b0;
			held_cnt_q   <= 2'd0;
			grp_len_q    <= utf8sf_pkg::LEN_NONE;
			valid_q      <= 1'b1;
		end else begin
			if (cfg_we)
				allow_ctrl_q <= cfg_wdata;
			if (take) begin
				if (hold) begin
					held_cnt_q <= cnt[1:0];
					if (grp_len_q == utf8sf_pkg::LEN_NONE)
						grp_len_q <= len_new;
				end else begin
					held_cnt_q <= 2'd0;
					grp_len_q  <= utf8sf_pkg::LEN_NONE;
					valid_q    <= in_last ? 1'b1 : (valid_q && !bad);
				end
			end
		end
	end

	// held bytes need no reset: only entries written in this group are read
	always_ff @(posedge clk) begin
		if (take && hold)
			held_q[held_cnt_q] <= in_byte;
	end

endmodule
`default_nettype wire

@@ rtl/utf8sf_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sf_fifo
// Short queue of group records between front and back.
// ----------------------------------------------------------------------------
module utf8sf_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  utf8sf_pkg::grp_rec_t     push_rec,
	output logic                     full,
	input  wire logic                pop,
	output utf8sf_pkg::grp_rec_t     head,
	output logic                     empty
);

	utf8sf_pkg::grp_rec_t            mem_q [utf8sf_pkg::FIFO_DEPTH];
	logic [utf8sf_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [utf8sf_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [utf8sf_pkg::FIFO_AW:0]    count_q;

	assign full  = count_q == (utf8sf_pkg::FIFO_AW+1)'(utf8sf_pkg::FIFO_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + (utf8sf_pkg::FIFO_AW)'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + (utf8sf_pkg::FIFO_AW)'(1);
			if (push && !pop)
				count_q <= count_q + (utf8sf_pkg::FIFO_AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (utf8sf_pkg::FIFO_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_rec;
	end

endmodule
`default_nettype wire

@@ rtl/utf8sf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8sf_back
// Unrolls each group record into output bytes, one per cycle unless
// out_ready holds the output, into an output register.
// ----------------------------------------------------------------------------
module utf8sf_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  utf8sf_pkg::grp_rec_t     head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               out_byte,
	output logic                     out_run_end,
	output logic                     out_buf_end,
	output logic                     out_buf_ok
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       run_end_q;
	logic       buf_end_q;
	logic       buf_ok_q;

	logic       load;
	logic       run_end;

	assign load    = !empty && (!out_valid_q || out_ready);
	assign run_end = idx_q == head.last_idx;
	assign pop     = load && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= run_end ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q    <= head.bad ? utf8sf_pkg::QMARK : head.bytes[idx_q];
			run_end_q <= run_end;
			buf_end_q <= run_end && head.buf_last;
			buf_ok_q  <= head.buf_ok;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign out_run_end = run_end_q;
	assign out_buf_end = buf_end_q;
	assign out_buf_ok  = buf_ok_q;

endmodule
`default_nettype wire
